// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rrpm_pkg.sv -----
// ----------------------------------------------------------------------------
// rrpm_pkg
// Shared widths, defaults and types of the round-robin packet merge.
// ----------------------------------------------------------------------------
package rrpm_pkg;

  localparam int NUM_INPUTS_DEF = 4;
  localparam int FIFO_DEPTH_DEF = 16;

  localparam int SOURCE_W  = 2;
  localparam int PAYLOAD_W = 32;
  localparam int STAMP_W   = 64;
  localparam int ACTIVE_W  = 3;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd4;

  // one buffered packet
  typedef struct packed {
    logic [PAYLOAD_W-1:0]        payload;
    logic signed [STAMP_W-1:0]   stamp;
    logic                        end_mark;
  } slot_data_t;

  // one merged result
  typedef struct packed {
    logic [PAYLOAD_W-1:0]        out_payload;
    logic signed [STAMP_W-1:0]   out_stamp;
    logic                        out_end_mark;
    logic [SOURCE_W-1:0]         out_source;
    logic                        last_of_run;
    logic                        all_done;
    logic                        dropped;
  } result_t;

  // controller -> output stage
  typedef struct packed {
    logic    load;
    result_t res;
  } out_load_t;

endpackage

// ----- hdl/rrpm_if.sv -----
// ----------------------------------------------------------------------------
// rrpm interfaces
// Arrival, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface packet_if;
  logic                                   valid;
  logic                                   ready;
  logic [rrpm_pkg::SOURCE_W-1:0]          src;
  logic [rrpm_pkg::PAYLOAD_W-1:0]         payload;
  logic signed [rrpm_pkg::STAMP_W-1:0]    stamp;
  logic                                   end_mark;
  logic                                   clear_ends;

  modport source (output valid, src, payload, stamp, end_mark, clear_ends,
                  input ready);
  modport sink   (input valid, src, payload, stamp, end_mark, clear_ends,
                  output ready);
endinterface

interface result_if;
  logic                                   valid;
  logic                                   ready;
  logic [rrpm_pkg::PAYLOAD_W-1:0]         out_payload;
  logic signed [rrpm_pkg::STAMP_W-1:0]    out_stamp;
  logic                                   out_end_mark;
  logic [rrpm_pkg::SOURCE_W-1:0]          out_source;
  logic                                   last_of_run;
  logic                                   all_done;
  logic                                   dropped;

  modport source (output valid, out_payload, out_stamp, out_end_mark, out_source,
                  last_of_run, all_done, dropped, input ready);
  modport sink   (input valid, out_payload, out_stamp, out_end_mark, out_source,
                  last_of_run, all_done, dropped, output ready);
endinterface

interface cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [rrpm_pkg::ACTIVE_W-1:0]          data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- hdl/round_robin_packet_merge.sv -----
// Operation: each transfer starts a dry counting pass, then an emitting pass;
// ended streams are skipped in both passes, and results are presented only in
// the emitting pass. With nothing to emit, a status result is presented instead.
// No new arrival is taken until the drain of the last one has finished.
// Reset: pointer, FIFO heads and counts, ended flags cleared, register to 4.
// ----------------------------------------------------------------------------
// round_robin_packet_merge
// Buffers tagged packets in per-source FIFOs held in one slot memory and
// drains them in round-robin order into a single result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module round_robin_packet_merge #(
  parameter int NUM_INPUTS = rrpm_pkg::NUM_INPUTS_DEF,
  parameter int FIFO_DEPTH = rrpm_pkg::FIFO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  packet_if.sink    arrival,
  result_if.source  merged,
  cfg_if.sink       cfg
);

  localparam int SLOTS  = NUM_INPUTS * FIFO_DEPTH;
  localparam int SLOT_W = $clog2(SLOTS);

  logic                 mem_we;
  logic [SLOT_W-1:0]    mem_waddr;
  rrpm_pkg::slot_data_t mem_wdata;
  logic                 mem_re;
  logic [SLOT_W-1:0]    mem_raddr;
  rrpm_pkg::slot_data_t mem_rdata;
  logic                 out_free;
  rrpm_pkg::out_load_t  ld;
  logic                 arr_xfer;

  assign arr_xfer = arrival.valid && arrival.ready;

  rrpm_slot_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rrpm_ctrl #(
    .NUM_INPUTS (NUM_INPUTS),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .arrival   (arrival),
    .cfg       (cfg),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_free  (out_free),
    .ld        (ld)
  );

  rrpm_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .ld       (ld),
    .out_free (out_free),
    .merged   (merged)
  );

  `ASSERT_IMPLIES(a_load_free, clk, rst, ld.load, out_free, "result loaded into busy register")
  `ASSERT_IMPLIES(a_write_on_xfer, clk, rst, mem_we, arr_xfer, "slot write without transfer")
  `ASSERT_NEXT(a_busy_after_xfer, clk, rst, arr_xfer, !arrival.ready, "arrival taken during drain")
  `ASSERT_IMPLIES(a_no_rw_overlap, clk, rst, mem_re, !mem_we, "slot read and write in one cycle")

endmodule

// ----- hdl/rrpm_slot_mem.sv -----
// ----------------------------------------------------------------------------
// rrpm_slot_mem
// Packet slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rrpm_slot_mem #(
  parameter int SLOTS = rrpm_pkg::NUM_INPUTS_DEF * rrpm_pkg::FIFO_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(SLOTS)-1:0]   waddr,
  input  rrpm_pkg::slot_data_t       wdata,
  input  logic                       re,
  input  logic [$clog2(SLOTS)-1:0]   raddr,
  output rrpm_pkg::slot_data_t       rdata
);

  rrpm_pkg::slot_data_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/rrpm_out_stage.sv -----
// ----------------------------------------------------------------------------
// rrpm_out_stage
// Result register; decouples the merge sequencer from the result channel.
// ----------------------------------------------------------------------------
module rrpm_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  rrpm_pkg::out_load_t  ld,
  output logic                 out_free,
  result_if.source             merged
);

  logic              valid;
  rrpm_pkg::result_t res;

  assign out_free = !valid || merged.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ld.load) begin
      valid <= 1'b1;
    end else if (merged.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      res <= ld.res;
    end
  end

  assign merged.valid        = valid;
  assign merged.out_payload  = res.out_payload;
  assign merged.out_stamp    = res.out_stamp;
  assign merged.out_end_mark = res.out_end_mark;
  assign merged.out_source   = res.out_source;
  assign merged.last_of_run  = res.last_of_run;
  assign merged.all_done     = res.all_done;
  assign merged.dropped      = res.dropped;

endmodule

// ----- hdl/rrpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrpm_ctrl
// Queue bookkeeping and drain sequencer. Per arrival the drain runs a dry
// pass that finds the emit count and the done flag, then, if there is anything
// to emit, a replay from a snapshot that emits the packets.
// ----------------------------------------------------------------------------
module rrpm_ctrl #(
  parameter int NUM_INPUTS = rrpm_pkg::NUM_INPUTS_DEF,
  parameter int FIFO_DEPTH = rrpm_pkg::FIFO_DEPTH_DEF,
  localparam int SLOTS     = NUM_INPUTS * FIFO_DEPTH,
  localparam int SLOT_W    = $clog2(SLOTS)
) (
  input  logic                  clk,
  input  logic                  rst,
  packet_if.sink                arrival,
  cfg_if.sink                   cfg,
  output logic                  mem_we,
  output logic [SLOT_W-1:0]     mem_waddr,
  output rrpm_pkg::slot_data_t  mem_wdata,
  output logic                  mem_re,
  output logic [SLOT_W-1:0]     mem_raddr,
  input  rrpm_pkg::slot_data_t  mem_rdata,
  input  logic                  out_free,
  output rrpm_pkg::out_load_t   ld
);

  localparam int PTR_W  = $clog2(NUM_INPUTS);
  localparam int HEAD_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int ACT_W  = $clog2(NUM_INPUTS + 1);
  localparam int N_W    = $clog2(SLOTS + 1);
  localparam logic [SLOT_W-1:0] DEPTH_L = SLOT_W'(FIFO_DEPTH);
  localparam logic [HEAD_W:0]   DEPTH_H = (HEAD_W + 1)'(FIFO_DEPTH);

  typedef enum logic [1:0] {IDLE, SCAN, FETCH, STATUS} state_t;

  state_t                        state;
  logic [rrpm_pkg::ACTIVE_W-1:0] active_reg;
  logic                          replay;

  // working queue state
  logic [PTR_W-1:0]  w_ptr;
  logic [HEAD_W-1:0] w_head  [NUM_INPUTS];
  logic [CNT_W-1:0]  w_cnt   [NUM_INPUTS];
  logic              w_ended [NUM_INPUTS];
  // snapshot taken after the arrival, restored for the replay
  logic [PTR_W-1:0]  c_ptr;
  logic [HEAD_W-1:0] c_head  [NUM_INPUTS];
  logic [CNT_W-1:0]  c_cnt   [NUM_INPUTS];
  logic              c_ended [NUM_INPUTS];

  logic [ACT_W-1:0] skips;
  logic [PTR_W-1:0] rd_ptr;
  logic [N_W-1:0]   n_total;
  logic [N_W-1:0]   k;
  logic             drop_r;
  logic             done_r;

  logic [ACT_W-1:0]  act;
  logic              accept;
  logic [PTR_W-1:0]  src_idx;
  logic              drop_now;
  logic [HEAD_W:0]   pos_sum;
  logic [HEAD_W-1:0] wr_pos;
  logic              arr_ended [NUM_INPUTS];
  logic [CNT_W-1:0]  arr_cnt   [NUM_INPUTS];
  logic [PTR_W-1:0]  arr_ptr;
  logic [PTR_W-1:0]  p;
  logic [PTR_W-1:0]  next_ptr;
  logic [HEAD_W-1:0] head_inc;
  logic              p_ended;
  logic              p_empty;
  logic              done_now;

  assign cfg.ready     = 1'b1;
  assign arrival.ready = (state == IDLE);
  assign accept        = arrival.valid && arrival.ready;

  always_comb begin
    if (active_reg == '0) begin
      act = ACT_W'(1);
    end else if (int'(active_reg) > NUM_INPUTS) begin
      act = ACT_W'(NUM_INPUTS);
    end else begin
      act = ACT_W'(active_reg);
    end
  end

  // arrival side
  always_comb begin
    src_idx  = PTR_W'(arrival.src);
    drop_now = (int'(arrival.src) >= int'(act))
            || (int'(w_cnt[src_idx]) >= FIFO_DEPTH);
    pos_sum  = (HEAD_W + 1)'(w_head[src_idx]) + (HEAD_W + 1)'(w_cnt[src_idx]);
    if (int'(pos_sum) >= FIFO_DEPTH) begin
      wr_pos = HEAD_W'(pos_sum - DEPTH_H);
    end else begin
      wr_pos = HEAD_W'(pos_sum);
    end
    for (int i = 0; i < NUM_INPUTS; i++) begin
      arr_ended[i] = arrival.clear_ends ? 1'b0 : w_ended[i];
      arr_cnt[i]   = w_cnt[i];
    end
    if (!drop_now) begin
      arr_cnt[src_idx] = w_cnt[src_idx] + 1'b1;
    end
    arr_ptr = (int'(w_ptr) >= int'(act)) ? '0 : w_ptr;
  end

  assign mem_we             = accept && !drop_now;
  assign mem_waddr          = SLOT_W'(src_idx) * DEPTH_L + SLOT_W'(wr_pos);
  assign mem_wdata.payload  = arrival.payload;
  assign mem_wdata.stamp    = arrival.stamp;
  assign mem_wdata.end_mark = arrival.end_mark;

  // drain step
  always_comb begin
    p        = w_ptr;
    p_ended  = w_ended[p];
    p_empty  = (w_cnt[p] == '0);
    next_ptr = (int'(p) + 1 >= int'(act)) ? '0 : p + 1'b1;
    head_inc = (int'(w_head[p]) + 1 >= FIFO_DEPTH) ? '0 : w_head[p] + 1'b1;
    done_now = 1'b1;
    for (int i = 0; i < NUM_INPUTS; i++) begin
      if (i < int'(act) && !w_ended[i]) begin
        done_now = 1'b0;
      end
    end
  end

  assign mem_re    = (state == SCAN) && !p_ended && !p_empty;
  assign mem_raddr = SLOT_W'(p) * DEPTH_L + SLOT_W'(w_head[p]);

  always_comb begin
    ld.load = out_free && (((state == FETCH) && replay) || (state == STATUS));
    ld.res.all_done = done_r;
    ld.res.dropped  = drop_r;
    if (state == STATUS) begin
      ld.res.out_payload  = '0;
      ld.res.out_stamp    = '0;
      ld.res.out_end_mark = 1'b0;
      ld.res.out_source   = '0;
      ld.res.last_of_run  = 1'b0;
    end else begin
      ld.res.out_payload  = mem_rdata.payload;
      ld.res.out_stamp    = mem_rdata.stamp;
      ld.res.out_end_mark = mem_rdata.end_mark;
      ld.res.out_source   = rrpm_pkg::SOURCE_W'(rd_ptr);
      ld.res.last_of_run  = ((k + 1'b1) == n_total);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      active_reg <= rrpm_pkg::ACTIVE_RESET;
      replay     <= 1'b0;
      w_ptr      <= '0;
      c_ptr      <= '0;
      skips      <= '0;
      rd_ptr     <= '0;
      n_total    <= '0;
      k          <= '0;
      drop_r     <= 1'b0;
      done_r     <= 1'b0;
      for (int i = 0; i < NUM_INPUTS; i++) begin
        w_head[i]  <= '0;
        w_cnt[i]   <= '0;
        w_ended[i] <= 1'b0;
        c_head[i]  <= '0;
        c_cnt[i]   <= '0;
        c_ended[i] <= 1'b0;
      end
    end else begin
      if (cfg.valid) begin
        active_reg <= cfg.data;
      end
      unique case (state)
        IDLE: begin
          if (arrival.valid) begin
            for (int i = 0; i < NUM_INPUTS; i++) begin
              w_ended[i] <= arr_ended[i];
              c_ended[i] <= arr_ended[i];
              w_cnt[i]   <= arr_cnt[i];
              c_cnt[i]   <= arr_cnt[i];
              c_head[i]  <= w_head[i];
            end
            w_ptr   <= arr_ptr;
            c_ptr   <= arr_ptr;
            drop_r  <= drop_now;
            n_total <= '0;
            skips   <= '0;
            replay  <= 1'b0;
            state   <= SCAN;
          end
        end
        SCAN: begin
          if (p_ended && (int'(skips) + 1 < int'(act))) begin
            skips <= skips + 1'b1;
            w_ptr <= next_ptr;
          end else if (!p_ended && !p_empty) begin
            w_head[p] <= head_inc;
            w_cnt[p]  <= w_cnt[p] - 1'b1;
            w_ptr     <= next_ptr;
            skips     <= '0;
            rd_ptr    <= p;
            state     <= FETCH;
          end else if (replay) begin
            state <= IDLE;
          end else begin
            // dry pass over: keep its flags, then either report status
            // or rewind to the snapshot and emit
            done_r <= done_now;
            if (n_total == '0) begin
              state <= STATUS;
            end else begin
              for (int i = 0; i < NUM_INPUTS; i++) begin
                w_head[i]  <= c_head[i];
                w_cnt[i]   <= c_cnt[i];
                w_ended[i] <= c_ended[i];
              end
              w_ptr  <= c_ptr;
              skips  <= '0;
              k      <= '0;
              replay <= 1'b1;
            end
          end
        end
        FETCH: begin
          if (!replay || out_free) begin
            if (mem_rdata.end_mark) begin
              w_ended[rd_ptr] <= 1'b1;
            end
            if (replay) begin
              k <= k + 1'b1;
            end else begin
              n_total <= n_total + 1'b1;
            end
            state <= SCAN;
          end
        end
        STATUS: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
